// ----- sv/asm_pkg.sv -----
// Shared types and codes of the array set membership block.
package asm_pkg;

  // Request kinds carried on the input tuser.
  localparam logic [1:0] ACT_LOOKUP = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  // Fixed field widths of the stream ports.
  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned IN_VALUE_W = 32;
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned OUT_DATA_W = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_UPDATE,
    ST_REPLY
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic scan;
    logic fetch_last;
    logic update;
    logic reply;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic hit;
    logic is_remove;
    logic out_free;
  } stat_t;

endpackage

// ----- sv/array_set_membership.sv -----
// Top level of the array set membership store: controller plus datapath.
//
//  channel   signals                      word contents (low bit up)
//  -------   --------------------------   -------------------------------------
//  request   s_axis_tvalid/tready/tdata   tdata: value[31:0]; tuser: action[1:0]
//  result    m_axis_tvalid/tready/tdata   tdata: found, count[4:0], status, 0
//
// One request at a time. From one accept to the next, the scan sets the
// time: one RAM read per entry through a single port, ending early on a hit.
// A remove that hits adds a fetch of the last entry, and the reply waits
// for the output to be free.
// Synchronous reset empties the set at once; entries are never cleared.
// A waiting result sits in the output register and holds the next reply
// back only while it stays untaken.
module array_set_membership #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: value[31:0]
  input  logic [asm_pkg::IN_VALUE_W-1:0]     s_axis_tdata,
  // tuser: action[1:0]
  input  logic [asm_pkg::ACTION_W-1:0]       s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata: found[0], count[5:1], status[6], zero pad[7]
  output logic [asm_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

  asm_pkg::cmd_t  cmd;
  asm_pkg::stat_t stat;

  // Sequence each request: accept, scan, optional fetch, update, reply.
  asm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold the entries, the count and the result word.
  asm_dpath #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_action (s_axis_tuser),
    .in_value  (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

  // Only one request in flight: accept drops ready for the next cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while another is in flight");

  // A reply never overwrites an untaken result.
  a_reply_free: assert property (@(posedge clk) disable iff (rst)
    cmd.reply |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result register overwritten");

  // Fetch of the last entry always leads straight to the update.
  a_fetch_update: assert property (@(posedge clk) disable iff (rst)
    cmd.fetch_last |=> cmd.update)
    else $error("fetch not followed by update");

  // A dropped insert never reports the value as present.
  a_drop_not_found: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[6]) |-> !m_axis_tdata[0])
    else $error("dropped insert flagged as found");

endmodule

// ----- sv/asm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module asm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/asm_ctrl.sv -----
// Controller state machine: sequences accept, scan, fetch, update and reply.
module asm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  asm_pkg::stat_t stat,
  output asm_pkg::cmd_t  cmd
);

  asm_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= asm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      asm_pkg::ST_IDLE: begin
        if (in_valid) state_next = asm_pkg::ST_SCAN;
      end
      asm_pkg::ST_SCAN: begin
        if (stat.scan_done) begin
          if (stat.hit && stat.is_remove) state_next = asm_pkg::ST_FETCH;
          else state_next = asm_pkg::ST_UPDATE;
        end
      end
      asm_pkg::ST_FETCH:  state_next = asm_pkg::ST_UPDATE;
      asm_pkg::ST_UPDATE: state_next = asm_pkg::ST_REPLY;
      asm_pkg::ST_REPLY: begin
        if (stat.out_free) state_next = asm_pkg::ST_IDLE;
      end
      default: state_next = asm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    unique case (state)
      asm_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      asm_pkg::ST_SCAN:   cmd.scan       = 1'b1;
      asm_pkg::ST_FETCH:  cmd.fetch_last = 1'b1;
      asm_pkg::ST_UPDATE: cmd.update     = 1'b1;
      asm_pkg::ST_REPLY:  cmd.reply      = stat.out_free;
      default: ;
    endcase
  end

endmodule

// ----- sv/asm_dpath.sv -----
// Datapath: entry RAM, scan pointer, compare stage, count and result register.
module asm_dpath #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  asm_pkg::cmd_t                       cmd,
  output asm_pkg::stat_t                      stat,
  input  logic [asm_pkg::ACTION_W-1:0]        in_action,
  input  logic [asm_pkg::IN_VALUE_W-1:0]      in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [asm_pkg::OUT_DATA_W-1:0]      out_data
);

  localparam int unsigned SW = (VALUE_WIDTH < asm_pkg::IN_VALUE_W) ?
                               VALUE_WIDTH : asm_pkg::IN_VALUE_W;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned HW = $clog2(DEPTH + 1);

  logic [asm_pkg::ACTION_W-1:0] act;
  logic [SW-1:0]                val;
  logic [HW-1:0]                held;
  logic [HW-1:0]                rd_ptr;
  logic                         cmp_valid;
  logic [AW-1:0]                cmp_slot;
  logic                         found;
  logic [AW-1:0]                slot;
  logic                         full_flag;
  logic                         out_found;
  logic [asm_pkg::COUNT_W-1:0]  out_count;
  logic                         out_status;

  logic                         issue;
  logic                         hit;
  logic                         is_insert;
  logic                         is_remove;
  logic                         store_full;
  logic                         we;
  logic [AW-1:0]                waddr;
  logic [SW-1:0]                wdata;
  logic [AW-1:0]                raddr;
  logic [SW-1:0]                rdata;
  logic [HW-1:0]                held_last;
  logic [asm_pkg::COUNT_W-1:0]  count5;

  asm_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign is_insert  = (act == asm_pkg::ACT_INSERT);
  assign is_remove  = (act == asm_pkg::ACT_REMOVE);
  assign store_full = (held == HW'(DEPTH));
  assign held_last  = held - HW'(1);

  // One read per scan cycle while unread entries remain; the compare acts on the registered read data.
  assign issue = cmd.scan && (rd_ptr != held);
  assign hit   = cmd.scan && cmp_valid && (rdata == val);
  assign raddr = cmd.fetch_last ? held_last[AW-1:0] : rd_ptr[AW-1:0];

  // Remove moves the last entry into the hole; insert appends.
  assign we    = cmd.update && ((is_remove && found) ||
                                (is_insert && !found && !store_full));
  assign waddr = is_remove ? slot : held[AW-1:0];
  assign wdata = is_remove ? rdata : val;

  generate
    if (HW >= asm_pkg::COUNT_W) begin : g_count_trunc
      assign count5 = held[asm_pkg::COUNT_W-1:0];
    end else begin : g_count_ext
      assign count5 = {{(asm_pkg::COUNT_W - HW){1'b0}}, held};
    end
  endgenerate

  assign stat.scan_done = hit || (cmd.scan && (rd_ptr == held) && !cmp_valid);
  assign stat.hit       = hit;
  assign stat.is_remove = is_remove;
  assign stat.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      cmp_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.accept) begin
        cmp_valid <= 1'b0;
      end else if (cmd.scan) begin
        cmp_valid <= issue;
      end
      if (cmd.update) begin
        if (is_remove && found) held <= held - HW'(1);
        else if (is_insert && !found && !store_full) held <= held + HW'(1);
      end
      if (cmd.reply) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act    <= in_action;
      val    <= in_value[SW-1:0];
      rd_ptr <= '0;
      found  <= 1'b0;
    end
    if (issue) begin
      rd_ptr   <= rd_ptr + HW'(1);
      cmp_slot <= rd_ptr[AW-1:0];
    end
    if (hit) begin
      found <= 1'b1;
      slot  <= cmp_slot;
    end
    if (cmd.update) begin
      full_flag <= is_insert && !found && store_full;
    end
    if (cmd.reply) begin
      out_found  <= found;
      out_count  <= count5;
      out_status <= full_flag;
    end
  end

  assign out_data = {1'b0, out_status, out_count, out_found};

endmodule
